[rtl/imu_frame_parser_top_defines.svh]
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; files that assert include it by its bare file name.
`ifndef IMU_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_FRAME_PARSER_TOP_DEFINES_SVH

// Implication checked on every rising clock edge, inactive while reset is held.
`define IFP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ifp_pkg.sv]
// Package of the IMU frame parser: result kinds, frame type codes, register indexes
// and the record passed from the framer to the scaler. No dependencies.
package ifp_pkg;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_GYRO  = 2'd1,
		KIND_ANGLE = 2'd2,
		KIND_MAG   = 2'd3
	} kind_t;

	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;

	localparam int PAYLOAD_KEPT = 6;
	localparam int AXES         = 3;
	localparam int SCALE_W      = 16;
	localparam int FS_W         = 12;
	localparam int AXIS_W       = 31;

	// Magnetometer words are raw counts placed above the 15 fraction bits.
	localparam logic [SCALE_W-1:0] MAG_SCALE = 16'h8000;

	localparam logic [1:0] CFG_ACCEL_FS = 2'd0;
	localparam logic [1:0] CFG_GYRO_FS  = 2'd1;
	localparam logic [1:0] CFG_ANGLE_FS = 2'd2;

	localparam logic [FS_W-1:0] ACCEL_FS_RESET = 12'd16;
	localparam logic [FS_W-1:0] GYRO_FS_RESET  = 12'd2000;
	localparam logic [FS_W-1:0] ANGLE_FS_RESET = 12'd180;

	typedef struct packed {
		kind_t                     kind;
		logic [AXES-1:0][15:0]     words;
		logic [SCALE_W-1:0]        scale;
	} frame_t;

endpackage

[rtl/ifp_framer.sv]
// Byte framer of the IMU frame parser: sync hunt, byte position, running checksum,
// type and payload capture. Depends on ifp_pkg.
module ifp_framer #(
	parameter int FRAME_BYTES = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    rx_byte,
	input  logic [ifp_pkg::FS_W-1:0]      accel_fs,
	input  logic [ifp_pkg::FS_W-1:0]      gyro_fs,
	input  logic [ifp_pkg::FS_W-1:0]      angle_fs,
	output logic                          frame_done,
	output ifp_pkg::frame_t               frame
);
	import ifp_pkg::*;

	localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] type_q;
	logic [7:0] payload_q [PAYLOAD_KEPT];
	logic       known_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (pos_q == '0) begin
				if (rx_byte == SYNC_BYTE) begin
					sum_q <= rx_byte;
					pos_q <= 4'd1;
				end
			end else if (pos_q != LAST_POS) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + 4'd1;
			end else begin
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q == 4'd1) begin
			type_q <= rx_byte;
		end
	end

	// Each payload byte has its own fixed position; short frames leave the tail alone.
	for (genvar i = 0; i < PAYLOAD_KEPT; i++) begin : g_payload
		if (i + 2 < FRAME_BYTES - 1) begin : g_kept
			always_ff @(posedge clk) begin
				if (accept && pos_q == 4'(i + 2)) begin
					payload_q[i] <= rx_byte;
				end
			end
		end else begin : g_unused
			always_ff @(posedge clk) begin
				payload_q[i] <= payload_q[i];
			end
		end
	end

	always_comb begin
		known_type  = 1'b1;
		frame.kind  = KIND_MAG;
		frame.scale = MAG_SCALE;
		unique case (type_q)
			TYPE_ACCEL: begin
				frame.kind  = KIND_ACCEL;
				frame.scale = SCALE_W'(accel_fs);
			end
			TYPE_GYRO: begin
				frame.kind  = KIND_GYRO;
				frame.scale = SCALE_W'(gyro_fs);
			end
			TYPE_ANGLE: begin
				frame.kind  = KIND_ANGLE;
				frame.scale = SCALE_W'(angle_fs);
			end
			TYPE_MAG: begin
				frame.kind  = KIND_MAG;
				frame.scale = MAG_SCALE;
			end
			default: begin
				known_type = 1'b0;
			end
		endcase
		for (int k = 0; k < AXES; k++) begin
			frame.words[k] = {payload_q[2 * k + 1], payload_q[2 * k]};
		end
	end

	assign frame_done = accept && (pos_q == LAST_POS) && (rx_byte == sum_q) && known_type;

endmodule

[rtl/ifp_scaler.sv]
// Scaler of the IMU frame parser: three signed-by-unsigned multiplies into the
// result register. Depends on ifp_pkg.
module ifp_scaler (
	input  logic                                  clk,
	input  logic                                  load,
	input  ifp_pkg::frame_t                       frame,
	output logic [1:0]                            kind,
	output logic signed [ifp_pkg::AXIS_W-1:0]     axis [ifp_pkg::AXES]
);
	import ifp_pkg::*;

	logic signed [15 + SCALE_W + 1:0] prod [AXES];

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			prod[k] = $signed(frame.words[k]) * $signed({1'b0, frame.scale});
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind <= frame.kind;
			for (int k = 0; k < AXES; k++) begin
				axis[k] <= prod[k][AXIS_W-1:0];
			end
		end
	end

endmodule

[rtl/imu_frame_parser_top.sv]
// Top level of the IMU frame parser: configuration registers, request pipeline
// and handshakes. Depends on ifp_pkg, ifp_framer, ifp_scaler and the defines header.
//
// Usage: the input channel carries one received serial byte per request on
// rx_byte (in_valid / in_stall). Bytes are dropped until the sync byte 0x55,
// which opens a frame of FRAME_BYTES bytes whose last byte is the 8-bit sum of the
// bytes before it. A frame with a good checksum and a known type (0x51..0x54)
// yields one result request on frame_kind / axis_x / axis_y / axis_z
// (out_valid / out_stall); every other byte yields nothing.
// Throughput is one byte per cycle while in_stall is low. After the checksum
// byte is accepted, a result passes through the frame register of this level
// and then the multiplier's result register.
// Stalls: the result register holds while out_stall is high; a second finished
// frame waits in the frame register, and in_stall is high while it waits behind
// the blocked result.
// Reset (arst_n low) returns the framer to sync hunting, empties both pipeline
// stages and loads the full-scale registers with 16, 2000 and 180.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index;
// write only while no frame is in progress or waiting.
`include "imu_frame_parser_top_defines.svh"

module imu_frame_parser_top #(
	parameter int FRAME_BYTES = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [ifp_pkg::FS_W-1:0]             cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           frame_kind,
	output logic signed [ifp_pkg::AXIS_W-1:0]    axis_x,
	output logic signed [ifp_pkg::AXIS_W-1:0]    axis_y,
	output logic signed [ifp_pkg::AXIS_W-1:0]    axis_z
);
	import ifp_pkg::*;

	logic [FS_W-1:0]        accel_fs_q;
	logic [FS_W-1:0]        gyro_fs_q;
	logic [FS_W-1:0]        angle_fs_q;
	logic                   accept;
	logic                   frame_done;
	frame_t                 frame;
	frame_t                 frame_s1;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   s2_free;
	logic                   move_s1;
	logic signed [AXIS_W-1:0] axis [AXES];
	logic                   mag_result;
	logic                   mag_frac;

	// Full-scale registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_fs_q <= ACCEL_FS_RESET;
			gyro_fs_q  <= GYRO_FS_RESET;
			angle_fs_q <= ANGLE_FS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACCEL_FS: accel_fs_q <= cfg_data;
				CFG_GYRO_FS:  gyro_fs_q  <= cfg_data;
				CFG_ANGLE_FS: angle_fs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The result register is free when empty or being taken this cycle; the frame
	// register then moves forward, and the input stalls only when it cannot.
	assign s2_free  = !valid_s2 || !out_stall;
	assign move_s1  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	ifp_framer #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.accel_fs   (accel_fs_q),
		.gyro_fs    (gyro_fs_q),
		.angle_fs   (angle_fs_q),
		.frame_done (frame_done),
		.frame      (frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_done) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_s1 <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	ifp_scaler u_scaler (
		.clk   (clk),
		.load  (move_s1),
		.frame (frame_s1),
		.kind  (frame_kind),
		.axis  (axis)
	);

	assign out_valid = valid_s2;
	assign axis_x    = axis[0];
	assign axis_y    = axis[1];
	assign axis_z    = axis[2];

	// Magnetometer result on the output, and any fraction bit set on its axes.
	assign mag_result = out_valid && (frame_kind == KIND_MAG);
	assign mag_frac   = |{axis_x[14:0], axis_y[14:0], axis_z[14:0]};

	// The input only stalls behind a blocked frame waiting in the frame register.
	`IFP_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && valid_s2 && out_stall, "stray in_stall")
	// Magnetometer results are raw counts, so the fraction bits are zero.
	`IFP_ASSERT_IMPL(a_mag_fraction, mag_result, !mag_frac, "magnetometer fraction bits set")
	// A taken result with nothing behind it leaves the output empty.
	`IFP_ASSERT_NEXT(a_drain, out_valid && !out_stall && !valid_s1, !out_valid, "result repeated")

endmodule

[test/tb_imu_frame_parser_top.sv]
// Self-checking testbench for imu_frame_parser_top: directed frames from a table, then random
// framed byte streams under several full-scale settings and handshake paces.
// Depends on ifp_pkg and the RTL of imu_frame_parser_top only.
`timescale 1ns / 100ps

module tb_imu_frame_parser_top;
	import ifp_pkg::*;

	// Frame length used by the instance and by the local parser model.
	localparam int FRAME_LEN = 11;
	// A result passes the frame and result registers after its checksum byte is taken.
	localparam int PIPE_LATENCY = 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BYTES_PER_PHASE = 150;
	localparam int PHASES = 6;
	// Index 3 is not a register; one write to it must leave all scales alone.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// How a directed row is checked: by the local model, as "no reading", or against
	// the values typed into the row.
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_RESULT,
		TYPED
	} check_t;

	// Handshake pace of a phase.
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SLOW_SENDER,
		PACE_SLOW_RECEIVER,
		PACE_LIGHT_BOTH
	} pace_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [AXIS_W-1:0]  x;
		logic signed [AXIS_W-1:0]  y;
		logic signed [AXIS_W-1:0]  z;
	} reading_t;

	typedef struct packed {
		logic                      lead_on;
		logic [7:0]                lead;
		logic [7:0]                ftype;
		logic [15:0]               wx;
		logic [15:0]               wy;
		logic [15:0]               wz;
		logic [15:0]               tail;
		logic [7:0]                sum_err;
		logic [3:0]                send_len;
		check_t                    check;
		kind_t                     kind;
		logic signed [AXIS_W-1:0]  ex;
		logic signed [AXIS_W-1:0]  ey;
		logic signed [AXIS_W-1:0]  ez;
	} frame_row_t;

	typedef struct packed {
		logic [FS_W-1:0]  accel;
		logic [FS_W-1:0]  gyro;
		logic [FS_W-1:0]  angle;
		pace_t            pace;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [FS_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] frame_kind;
	logic signed [AXIS_W-1:0] axis_x;
	logic signed [AXIS_W-1:0] axis_y;
	logic signed [AXIS_W-1:0] axis_z;

	imu_frame_parser_top #(
		.FRAME_BYTES(FRAME_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_kind(frame_kind),
		.axis_x(axis_x),
		.axis_y(axis_y),
		.axis_z(axis_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Directed frames. The first rows run at the reset scales (16, 2000, 180), so
	// their readings are written out by hand: the largest or smallest word of
	// every known type. Bad checksums and unknown types (the sync value among them)
	// must give nothing. The later rows carry the sync value inside the payload and
	// as the checksum, and a cut frame that swallows the start of the next one;
	// those are left to the local model.
	frame_row_t directed_rows [15] = '{
		'{1'b1, 8'hFF, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 8'h00,
			4'(FRAME_LEN), TYPED, KIND_ACCEL, 31'sd524272, -31'sd524288, 31'sd0},
		'{1'b0, 8'h00, TYPE_GYRO, 16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFF, 8'h00,
			4'(FRAME_LEN), TYPED, KIND_GYRO, 31'sd2000, -31'sd2000, 31'sd65534000},
		'{1'b1, 8'h00, TYPE_ANGLE, 16'h8000, 16'h0001, 16'hFFFF, 16'h1234, 8'h00,
			4'(FRAME_LEN), TYPED, KIND_ANGLE, -31'sd5898240, 31'sd180, -31'sd180},
		'{1'b0, 8'h00, TYPE_MAG, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 8'h00,
			4'(FRAME_LEN), TYPED, KIND_MAG, 31'sd1073709056, -31'sd1073741824, 31'sd0},
		'{1'b0, 8'h00, TYPE_MAG, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 8'h00,
			4'(FRAME_LEN), TYPED, KIND_MAG, -31'sd32768, 31'sd32768, -31'sd1073741824},
		'{1'b0, 8'h00, TYPE_ACCEL, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h01,
			4'(FRAME_LEN), NO_RESULT, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, TYPE_GYRO, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 8'h80,
			4'(FRAME_LEN), NO_RESULT, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, 8'h50, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 8'h00,
			4'(FRAME_LEN), NO_RESULT, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, SYNC_BYTE, 16'h5555, 16'h0000, 16'hFFFF, 16'h0000, 8'h00,
			4'(FRAME_LEN), NO_RESULT, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00,
			4'(FRAME_LEN), NO_RESULT, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, TYPE_MAG, 16'h5555, 16'h0055, 16'h5500, 16'h5555, 8'h00,
			4'(FRAME_LEN), BY_MODEL, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, TYPE_ACCEL, 16'h00AF, 16'h0000, 16'h0000, 16'h0000, 8'h00,
			4'(FRAME_LEN), BY_MODEL, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, TYPE_ANGLE, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000, 8'h00,
			4'd4, BY_MODEL, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b0, 8'h00, TYPE_GYRO, 16'h1234, 16'hABCD, 16'h8001, 16'h0000, 8'h00,
			4'(FRAME_LEN), BY_MODEL, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0},
		'{1'b1, 8'hAA, TYPE_ACCEL, 16'hC3C3, 16'h3C3C, 16'h00FF, 16'hFF00, 8'h00,
			4'(FRAME_LEN), BY_MODEL, KIND_ACCEL, 31'sd0, 31'sd0, 31'sd0}
	};

	// Register settings of the random phases: the range ends, the values outside
	// the range that the block still takes as given, alternating bit patterns,
	// and a return to the reset values.
	phase_t phase_plan [PHASES] = '{
		'{12'd1, 12'd1, 12'd1, PACE_FULL},
		'{12'd4000, 12'd4000, 12'd4000, PACE_SLOW_SENDER},
		'{12'd0, 12'd4095, 12'd2048, PACE_SLOW_RECEIVER},
		'{12'd4095, 12'd0, 12'd1, PACE_LIGHT_BOTH},
		'{12'd2730, 12'd1365, 12'd4000, PACE_FULL},
		'{ACCEL_FS_RESET, GYRO_FS_RESET, ANGLE_FS_RESET, PACE_SLOW_RECEIVER}
	};

	logic [7:0] known_types [4] = '{TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE, TYPE_MAG};

	// Local copy of the full-scale registers and of the parser state.
	logic [FS_W-1:0] fs_accel;
	logic [FS_W-1:0] fs_gyro;
	logic [FS_W-1:0] fs_angle;
	int hunt_pos;
	logic [7:0] sum_acc;
	logic [7:0] type_seen;
	logic [7:0] payload_seen [PAYLOAD_KEPT];

	// Readings the block still owes, oldest first.
	reading_t expected_readings [$];

	check_t row_check = BY_MODEL;
	reading_t row_exp;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int readings_checked = 0;
	int bytes_fed = 0;
	int unsigned cycle_count = 0;

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic signed [AXIS_W-1:0] scaled_axis(input int idx,
			input logic [SCALE_W-1:0] scale);
		longint word;
		longint product;
		word = longint'($signed({payload_seen[2*idx+1], payload_seen[2*idx]}));
		product = word * longint'(scale);
		return product[AXIS_W-1:0];
	endfunction

	// Steps the local parser by one byte. A reading comes out only on the last
	// byte of a frame whose checksum matches and whose type is known.
	task automatic parse_byte(input logic [7:0] b, output bit got, output reading_t r);
		logic [SCALE_W-1:0] scale;
		got = 1'b0;
		r = '0;
		scale = '0;
		if (hunt_pos == 0) begin
			if (b == SYNC_BYTE) begin
				sum_acc = b;
				hunt_pos = 1;
			end
		end else if (hunt_pos < FRAME_LEN - 1) begin
			if (hunt_pos == 1)
				type_seen = b;
			else if (hunt_pos - 2 < PAYLOAD_KEPT)
				payload_seen[hunt_pos-2] = b;
			sum_acc = sum_acc + b;
			hunt_pos++;
		end else begin
			hunt_pos = 0;
			if (b == sum_acc) begin
				got = 1'b1;
				case (type_seen)
					TYPE_ACCEL: begin
						r.kind = KIND_ACCEL;
						scale = SCALE_W'(fs_accel);
					end
					TYPE_GYRO: begin
						r.kind = KIND_GYRO;
						scale = SCALE_W'(fs_gyro);
					end
					TYPE_ANGLE: begin
						r.kind = KIND_ANGLE;
						scale = SCALE_W'(fs_angle);
					end
					TYPE_MAG: begin
						r.kind = KIND_MAG;
						scale = MAG_SCALE;
					end
					default: got = 1'b0;
				endcase
				r.x = scaled_axis(0, scale);
				r.y = scaled_axis(1, scale);
				r.z = scaled_axis(2, scale);
			end
		end
	endtask

	// Offers one byte as a request, with random idle cycles in front as the pace
	// asks, and holds it until the block takes it. The expectation is queued at
	// the edge that takes the byte, well before any reading can appear.
	task automatic feed_byte(input logic [7:0] b);
		bit got;
		reading_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_fed++;
		parse_byte(b, got, r);
		if (got && row_check == TYPED)
			r = row_exp;
		if (got && row_check != NO_RESULT)
			expected_readings.push_back(r);
	endtask

	// Sends the first send_len bytes of a frame. The payload holds eight bytes,
	// lowest byte first; sum_err is added to the correct checksum.
	task automatic send_frame(input logic [7:0] ftype, input logic [63:0] payload,
			input logic [7:0] sum_err, input int send_len);
		logic [7:0] sum;
		logic [7:0] b;
		sum = SYNC_BYTE + ftype;
		for (int i = 0; i < FRAME_LEN - 3; i++)
			sum = sum + payload[8*i +: 8];
		for (int k = 0; k < send_len; k++) begin
			if (k == 0)
				b = SYNC_BYTE;
			else if (k == 1)
				b = ftype;
			else if (k < FRAME_LEN - 1)
				b = payload[8*(k-2) +: 8];
			else
				b = sum + sum_err;
			feed_byte(b);
		end
	endtask

	// Payload bytes lean toward the values that make the extreme words.
	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return 8'h00;
		if (pick < 30)
			return 8'hFF;
		if (pick < 36)
			return 8'h80;
		if (pick < 42)
			return 8'h7F;
		if (pick < 47)
			return SYNC_BYTE;
		return 8'($urandom);
	endfunction

	// Mostly well-formed frames of known types with random content; the rest is
	// line noise, unknown types, bad checksums and frames cut short.
	task automatic random_frame();
		logic [7:0] ftype;
		logic [63:0] payload;
		logic [7:0] sum_err;
		int send_len;
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(1, 4))
				feed_byte(8'($urandom));
		if ($urandom_range(99) < 85)
			ftype = known_types[$urandom_range(3)];
		else
			ftype = 8'($urandom);
		for (int i = 0; i < 8; i++)
			payload[8*i +: 8] = payload_byte();
		sum_err = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
		send_len = ($urandom_range(99) < 6) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
		send_frame(ftype, payload, sum_err, send_len);
	endtask

	// Brings the block to rest: finishes any partial frame with filler bytes,
	// waits for every owed reading and then for the pipeline to drain.
	task automatic settle_parser();
		while (hunt_pos != 0)
			feed_byte(8'h00);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	// Writes the three full-scale registers on consecutive edges, and optionally
	// the unused index with all ones, which must change nothing.
	task automatic load_full_scales(input logic [FS_W-1:0] a, input logic [FS_W-1:0] g,
			input logic [FS_W-1:0] n, input bit poke_unused);
		logic [1:0] regs [4];
		logic [FS_W-1:0] vals [4];
		int count;
		regs = '{CFG_ACCEL_FS, CFG_GYRO_FS, CFG_ANGLE_FS, CFG_UNUSED};
		vals = '{a, g, n, {FS_W{1'b1}}};
		count = poke_unused ? 4 : 3;
		for (int i = 0; i < count; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		fs_accel = a;
		fs_gyro = g;
		fs_angle = n;
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			PACE_SLOW_SENDER: begin
				send_gap_pct = 71;
				stall_pct = 0;
			end
			PACE_SLOW_RECEIVER: begin
				send_gap_pct = 0;
				stall_pct = 71;
			end
			default: begin
				send_gap_pct = 6;
				stall_pct = 6;
			end
		endcase
	endtask

	// Result side: checks every reading the block hands over against the oldest
	// one owed, field by field, and draws the next stall.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					flag_error($sformatf("reading kind %0d with none owed", frame_kind));
				end else begin
					want = expected_readings.pop_front();
					readings_checked++;
					if (frame_kind !== want.kind)
						flag_error($sformatf("frame_kind %0d, expected %0d",
							frame_kind, want.kind));
					if (axis_x !== want.x)
						flag_error($sformatf("axis_x %0d, expected %0d", axis_x, want.x));
					if (axis_y !== want.y)
						flag_error($sformatf("axis_y %0d, expected %0d", axis_y, want.y));
					if (axis_z !== want.z)
						flag_error($sformatf("axis_z %0d, expected %0d", axis_z, want.z));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ACCEL_FS;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		fs_accel = ACCEL_FS_RESET;
		fs_gyro = GYRO_FS_RESET;
		fs_angle = ANGLE_FS_RESET;
		hunt_pos = 0;
		sum_acc = 8'h00;
		type_seen = 8'h00;
		foreach (payload_seen[i])
			payload_seen[i] = 8'h00;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames run back to back at the reset scales.
		set_pace(PACE_FULL);
		foreach (directed_rows[i]) begin
			row_check = directed_rows[i].check;
			row_exp = '{directed_rows[i].kind, directed_rows[i].ex, directed_rows[i].ey,
				directed_rows[i].ez};
			if (directed_rows[i].lead_on)
				feed_byte(directed_rows[i].lead);
			send_frame(directed_rows[i].ftype, {directed_rows[i].tail, directed_rows[i].wz,
				directed_rows[i].wy, directed_rows[i].wx}, directed_rows[i].sum_err,
				int'(directed_rows[i].send_len));
		end
		row_check = BY_MODEL;
		settle_parser();

		// Random phases. Registers are only written with the block at rest.
		for (int p = 0; p < PHASES; p++) begin
			load_full_scales(phase_plan[p].accel, phase_plan[p].gyro, phase_plan[p].angle,
				p == 2);
			set_pace(phase_plan[p].pace);
			target = bytes_fed + BYTES_PER_PHASE;
			while (bytes_fed < target)
				random_frame();
			settle_parser();
		end

		$display("Fed %0d bytes: %0d directed frames, then %0d register settings at four paces.",
			bytes_fed, $size(directed_rows), PHASES);
		$display("Checked %0d readings, %0d mismatches.", readings_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
